// File: rtl/core/tagged_fifo_with_search_delete_macros.svh
// ----------------------------------------------------------------------------
// Tagged FIFO assertion macros
// Shorthand for the clocked, reset-qualified checks used in the RTL.
// ----------------------------------------------------------------------------
`ifndef TAGGED_FIFO_WITH_SEARCH_DELETE_MACROS_SVH
`define TAGGED_FIFO_WITH_SEARCH_DELETE_MACROS_SVH

// The condition must hold at every clock edge outside reset.
`define TFSD_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// When the antecedent holds, the consequent must hold in the next cycle.
`define TFSD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/core/tfsd_pkg.sv
// ----------------------------------------------------------------------------
// Tagged FIFO package
// Shared types, codes and default sizes of the tagged FIFO.
// ----------------------------------------------------------------------------
package tfsd_pkg;

  localparam int DEPTH_DEF     = 16;
  localparam int ITEM_BITS_DEF = 32;
  localparam int TAG_BITS_DEF  = 32;

  localparam int OP_W   = 3;
  localparam int CAP_W  = 5;
  localparam int REG_W  = 32;
  localparam int ADDR_W = 3;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  // Register index, taken from the word part of the address.
  localparam logic REG_CAPACITY = 1'b0;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH   = 3'd0,
    OP_POP    = 3'd1,
    OP_SEARCH = 3'd2,
    OP_DELETE = 3'd3,
    OP_CLEAR  = 3'd4,
    OP_DUMP   = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_APPLY,
    ST_DUMP
  } state_t;

  typedef enum logic [2:0] {
    CH_HOLD,
    CH_PUSH,
    CH_POP,
    CH_DELETE,
    CH_ROTATE
  } chain_op_t;

  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctl_t;

endpackage

// File: rtl/core/tfsd_cell.sv
// ----------------------------------------------------------------------------
// Tagged FIFO cell
// Holds one entry; takes its neighbor's entry or a loaded one, and compares.
// ----------------------------------------------------------------------------
module tfsd_cell
  import tfsd_pkg::*;
#(
  parameter int ITEM_BITS = ITEM_BITS_DEF,
  parameter int TAG_BITS  = TAG_BITS_DEF
) (
  input  logic                 clk,
  input  cell_ctl_t            ctl,
  input  logic [ITEM_BITS-1:0] next_value,
  input  logic [TAG_BITS-1:0]  next_tag,
  input  logic [ITEM_BITS-1:0] load_value,
  input  logic [TAG_BITS-1:0]  load_tag,
  input  logic [ITEM_BITS-1:0] key_value,
  input  logic [TAG_BITS-1:0]  key_tag,
  input  logic                 key_is_tag,
  output logic [ITEM_BITS-1:0] value,
  output logic [TAG_BITS-1:0]  tag,
  output logic                 eq
);

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      value <= next_value;
      tag   <= next_tag;
    end else if (ctl.load) begin
      value <= load_value;
      tag   <= load_tag;
    end
  end

  assign eq = key_is_tag ? (tag == key_tag) : (value == key_value);

endmodule

// File: rtl/core/tfsd_chain.sv
// ----------------------------------------------------------------------------
// Tagged FIFO cell chain
// Row of entry cells with head at cell zero, plus per-cell control and search.
// ----------------------------------------------------------------------------
module tfsd_chain
  import tfsd_pkg::*;
#(
  parameter int DEPTH     = DEPTH_DEF,
  parameter int ITEM_BITS = ITEM_BITS_DEF,
  parameter int TAG_BITS  = TAG_BITS_DEF
) (
  input  logic                         clk,
  input  chain_op_t                    op,
  input  logic [$clog2(DEPTH+1)-1:0]   count,
  input  logic [ITEM_BITS-1:0]         push_value,
  input  logic [TAG_BITS-1:0]          push_tag,
  input  logic [ITEM_BITS-1:0]         key_value,
  input  logic [TAG_BITS-1:0]          key_tag,
  input  logic                         key_is_tag,
  input  logic [DEPTH-1:0]             sel,
  output logic [DEPTH-1:0]             first,
  output logic [ITEM_BITS-1:0]         head_value,
  output logic [TAG_BITS-1:0]          head_tag,
  output logic [ITEM_BITS-1:0]         tail_value,
  output logic [TAG_BITS-1:0]          tail_tag,
  output logic [TAG_BITS-1:0]          sel_tag
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = $clog2(DEPTH);

  logic [ITEM_BITS-1:0] cell_value [DEPTH];
  logic [TAG_BITS-1:0]  cell_tag   [DEPTH];
  logic [ITEM_BITS-1:0] next_value [DEPTH];
  logic [TAG_BITS-1:0]  next_tag   [DEPTH];
  cell_ctl_t            ctl        [DEPTH];
  logic [DEPTH-1:0]     eq;
  logic [DEPTH-1:0]     valid;
  logic [DEPTH-1:0]     match;
  logic [DEPTH-1:0]     ge_mask;
  logic [ITEM_BITS-1:0] load_value;
  logic [TAG_BITS-1:0]  load_tag;
  logic [IW-1:0]        tail_idx;

  assign load_value = (op == CH_ROTATE) ? cell_value[0] : push_value;
  assign load_tag   = (op == CH_ROTATE) ? cell_tag[0]   : push_tag;
  assign ge_mask    = ~(sel - DEPTH'(1));

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    assign valid[i] = CW'(i) < count;

    if (i < DEPTH - 1) begin : g_mid
      assign next_value[i] = cell_value[i+1];
      assign next_tag[i]   = cell_tag[i+1];
    end else begin : g_end
      assign next_value[i] = '0;
      assign next_tag[i]   = '0;
    end

    always_comb begin
      ctl[i] = '0;
      unique case (op)
        CH_PUSH:   ctl[i].load  = (CW'(i) == count);
        CH_POP:    ctl[i].shift = 1'b1;
        CH_DELETE: ctl[i].shift = ge_mask[i];
        CH_ROTATE: begin
          ctl[i].shift = CW'(i + 1) < count;
          ctl[i].load  = CW'(i + 1) == count;
        end
        default:   ctl[i] = '0;
      endcase
    end

    tfsd_cell #(
      .ITEM_BITS (ITEM_BITS),
      .TAG_BITS  (TAG_BITS)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl[i]),
      .next_value (next_value[i]),
      .next_tag   (next_tag[i]),
      .load_value (load_value),
      .load_tag   (load_tag),
      .key_value  (key_value),
      .key_tag    (key_tag),
      .key_is_tag (key_is_tag),
      .value      (cell_value[i]),
      .tag        (cell_tag[i]),
      .eq         (eq[i])
    );
  end

  // The lowest set bit is the match closest to the head.
  assign match = eq & valid;
  assign first = match & (~match + DEPTH'(1));

  assign tail_idx   = IW'(count - CW'(1));
  assign head_value = (count != '0) ? cell_value[0] : '0;
  assign head_tag   = cell_tag[0];
  assign tail_value = (count != '0) ? cell_value[tail_idx] : '0;
  assign tail_tag   = cell_tag[tail_idx];

  always_comb begin
    sel_tag = '0;
    for (int i = 0; i < DEPTH; i++) begin
      sel_tag = sel_tag | (sel[i] ? cell_tag[i] : '0);
    end
  end

endmodule

// File: rtl/core/tagged_fifo_with_search_delete.sv
// ----------------------------------------------------------------------------
// Tagged FIFO with search and delete
// Bounded queue of tagged values held in a chain of cells, head at cell zero.
// ----------------------------------------------------------------------------
// Channel   Dir  Contents
// s_*       in   request: op, value, tag in tdata
// m_*       out  result: ok, data, found_tag, count, head_value, tail_value;
//                tlast marks the final result of a request
// apb       in   capacity_limit at byte address 0
//
// On a request, the accept edge registers the command and the first-match
// vector from the per-cell compares; a later edge, once the result register is
// free, updates the chain and loads the result register. A dump of n entries
// gives one result per cycle while results are taken, by rotating the chain. A
// stalled result holds the next request in its command register. Synchronous
// reset empties the queue and sets capacity_limit to 16.
// ----------------------------------------------------------------------------
`include "tagged_fifo_with_search_delete_macros.svh"

module tagged_fifo_with_search_delete
  import tfsd_pkg::*;
#(
  parameter int DEPTH     = DEPTH_DEF,
  parameter int ITEM_BITS = ITEM_BITS_DEF,
  parameter int TAG_BITS  = TAG_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // op, value, tag
  input  logic [((OP_W + ITEM_BITS + TAG_BITS + 7) / 8) * 8 - 1:0] s_tdata,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // ok, data, found_tag, count, head_value, tail_value
  output logic [((1 + 4 * ITEM_BITS - ITEM_BITS + TAG_BITS + $clog2(DEPTH + 1) + 7) / 8) * 8
                - 1:0] m_tdata,
  output logic                  m_tlast,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [ADDR_W-1:0]     paddr,
  input  logic [REG_W-1:0]      pwdata,
  output logic [REG_W-1:0]      prdata,
  output logic                  pready
);

  localparam int CW          = $clog2(DEPTH + 1);
  localparam int LW          = (CW > CAP_W) ? CW : CAP_W;
  localparam int OUT_W       = 1 + 3 * ITEM_BITS + TAG_BITS + CW;
  localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

  state_t               state;
  state_t               state_next;
  logic [CW-1:0]        count;
  logic [CW-1:0]        count_next;
  logic [CW-1:0]        dump_left;
  logic [CW-1:0]        dump_left_next;
  logic [CAP_W-1:0]     cap;
  logic [DEPTH-1:0]     hit;
  logic [OP_W-1:0]      cmd_op;
  logic [ITEM_BITS-1:0] cmd_value;

  logic                 out_valid;
  logic                 out_ok;
  logic [ITEM_BITS-1:0] out_data;
  logic [TAG_BITS-1:0]  out_tag;
  logic                 out_last;
  logic                 out_hold;
  logic [ITEM_BITS-1:0] head_hold;
  logic [ITEM_BITS-1:0] tail_hold;

  logic                 in_accept;
  logic                 out_free;
  logic                 out_load;
  logic                 ok_next;
  logic [ITEM_BITS-1:0] data_next;
  logic [TAG_BITS-1:0]  tag_next;
  logic                 last_next;
  logic                 hold_next;
  logic                 dump_start;
  logic                 push_ok;
  logic                 cfg_write;

  logic [OP_W-1:0]      in_op;
  logic [ITEM_BITS-1:0] in_value;
  logic [TAG_BITS-1:0]  in_tag;

  chain_op_t            ch_op;
  logic [TAG_BITS-1:0]  push_tag;
  logic [DEPTH-1:0]     first;
  logic [ITEM_BITS-1:0] head_value;
  logic [TAG_BITS-1:0]  head_tag;
  logic [ITEM_BITS-1:0] tail_value;
  logic [TAG_BITS-1:0]  tail_tag;
  logic [TAG_BITS-1:0]  sel_tag;

  assign in_op    = s_tdata[OP_W-1:0];
  assign in_value = s_tdata[OP_W +: ITEM_BITS];
  assign in_tag   = s_tdata[OP_W + ITEM_BITS +: TAG_BITS];

  assign in_accept = s_tvalid && s_tready;
  assign out_free  = !out_valid || m_tready;
  assign push_ok   = (count < CW'(DEPTH)) && (LW'(count) < LW'(cap));
  assign push_tag  = (count == '0) ? TAG_BITS'(1) : tail_tag + TAG_BITS'(1);

  // Configuration port.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_CAPACITY);
  assign prdata    = (paddr[2] == REG_CAPACITY) ? REG_W'(cap) : '0;

  tfsd_chain #(
    .DEPTH     (DEPTH),
    .ITEM_BITS (ITEM_BITS),
    .TAG_BITS  (TAG_BITS)
  ) u_chain (
    .clk        (clk),
    .op         (ch_op),
    .count      (count),
    .push_value (cmd_value),
    .push_tag   (push_tag),
    .key_value  (in_value),
    .key_tag    (in_tag),
    .key_is_tag (in_op == OP_DELETE),
    .sel        (hit),
    .first      (first),
    .head_value (head_value),
    .head_tag   (head_tag),
    .tail_value (tail_value),
    .tail_tag   (tail_tag),
    .sel_tag    (sel_tag)
  );

  always_comb begin
    state_next     = state;
    count_next     = count;
    dump_left_next = dump_left;
    ch_op          = CH_HOLD;
    out_load       = 1'b0;
    ok_next        = 1'b0;
    data_next      = '0;
    tag_next       = '0;
    last_next      = 1'b1;
    hold_next      = 1'b0;
    dump_start     = 1'b0;
    s_tready       = (state == ST_IDLE);
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          state_next = ST_APPLY;
        end
      end
      ST_APPLY: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
          unique case (cmd_op)
            OP_PUSH: begin
              if (push_ok) begin
                ok_next    = 1'b1;
                ch_op      = CH_PUSH;
                count_next = count + CW'(1);
              end
            end
            OP_POP: begin
              if (count != '0) begin
                ok_next    = 1'b1;
                data_next  = head_value;
                ch_op      = CH_POP;
                count_next = count - CW'(1);
              end
            end
            OP_SEARCH: begin
              ok_next  = |hit;
              tag_next = sel_tag;
            end
            OP_DELETE: begin
              if (|hit) begin
                ok_next    = 1'b1;
                ch_op      = CH_DELETE;
                count_next = count - CW'(1);
              end
            end
            OP_CLEAR: begin
              ok_next    = 1'b1;
              count_next = '0;
            end
            OP_DUMP: begin
              if (count != '0) begin
                ok_next        = 1'b1;
                data_next      = head_value;
                tag_next       = head_tag;
                hold_next      = 1'b1;
                dump_start     = 1'b1;
                ch_op          = CH_ROTATE;
                last_next      = (count == CW'(1));
                dump_left_next = count - CW'(1);
                if (count != CW'(1)) begin
                  state_next = ST_DUMP;
                end
              end
            end
            default: ok_next = 1'b0;
          endcase
        end
      end
      ST_DUMP: begin
        if (out_free) begin
          out_load       = 1'b1;
          ok_next        = 1'b1;
          data_next      = head_value;
          tag_next       = head_tag;
          hold_next      = 1'b1;
          ch_op          = CH_ROTATE;
          last_next      = (dump_left == CW'(1));
          dump_left_next = dump_left - CW'(1);
          if (dump_left == CW'(1)) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      dump_left <= '0;
      cap       <= CAP_RESET;
      hit       <= '0;
      out_valid <= 1'b0;
      out_hold  <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      dump_left <= dump_left_next;
      if (cfg_write) begin
        cap <= pwdata[CAP_W-1:0];
      end
      if (in_accept) begin
        hit <= ((in_op == OP_DELETE) && (in_tag == '0)) ? '0 : first;
      end
      if (out_load) begin
        out_valid <= 1'b1;
        out_hold  <= hold_next;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      cmd_op    <= in_op;
      cmd_value <= in_value;
    end
    if (out_load) begin
      out_ok   <= ok_next;
      out_data <= data_next;
      out_tag  <= tag_next;
      out_last <= last_next;
    end
    if (dump_start) begin
      head_hold <= head_value;
      tail_hold <= tail_value;
    end
  end

  // Count, head and tail follow the chain; during a dump the chain rotates,
  // so the values captured at its start are shown instead.
  assign m_tvalid = out_valid;
  assign m_tlast  = out_last;
  assign m_tdata  = OUT_TDATA_W'({out_hold ? tail_hold : tail_value,
                                  out_hold ? head_hold : head_value,
                                  count, out_tag, out_data, out_ok});

  `TFSD_ASSERT_ALWAYS(a_count_bound, count <= CW'(DEPTH), "count exceeds depth")
  `TFSD_ASSERT_ALWAYS(a_hit_onehot, $onehot0(hit), "more than one first match")
  `TFSD_ASSERT_ALWAYS(a_dump_nonempty, (state != ST_DUMP) || (count != '0), "dump of empty queue")
  `TFSD_ASSERT_NEXT(a_stall_stable, m_tvalid && !m_tready, $stable(count), "count moved under stall")
  `TFSD_ASSERT_NEXT(a_push_grows, (state == ST_APPLY) && out_free && (cmd_op == OP_PUSH) && push_ok, count == $past(count) + CW'(1), "push did not grow queue")

endmodule

// File: dv/tfsd_queue_checker.sv
// ----------------------------------------------------------------------------
// Tagged FIFO result checker
// Watches the request, result and register channels of the tagged FIFO, keeps
// its own copy of the queue and the capacity limit, works out the results of
// every accepted request and compares each accepted result with the oldest
// one still outstanding.
// ----------------------------------------------------------------------------
module tfsd_queue_checker
  import tfsd_pkg::*;
#(
  parameter int S_W = 72,
  parameter int M_W = 136
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  input  logic              s_tready,
  input  logic [S_W-1:0]    s_tdata,
  input  logic              m_tvalid,
  input  logic              m_tready,
  input  logic [M_W-1:0]    m_tdata,
  input  logic              m_tlast,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [REG_W-1:0]  pwdata,
  input  logic              pready,
  output int                fail_count,
  output int                pending,
  output logic [TAG_BITS_DEF-1:0] live_tag
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = DEPTH_DEF;
  localparam int IW    = ITEM_BITS_DEF;
  localparam int TW    = TAG_BITS_DEF;
  localparam int CNT_W = $clog2(DEPTH + 1);

  localparam int DATA_LSB  = 1;
  localparam int FTAG_LSB  = DATA_LSB + IW;
  localparam int COUNT_LSB = FTAG_LSB + TW;
  localparam int HEAD_LSB  = COUNT_LSB + CNT_W;
  localparam int TAIL_LSB  = HEAD_LSB + IW;

  typedef struct {
    logic             ok;
    logic [IW-1:0]    data;
    logic [TW-1:0]    found_tag;
    logic [CNT_W-1:0] count;
    logic [IW-1:0]    head_value;
    logic [IW-1:0]    tail_value;
    logic             last;
  } queue_result_t;

  logic [IW-1:0]    q_value [DEPTH];
  logic [TW-1:0]    q_tag   [DEPTH];
  int unsigned      q_len;
  logic [CAP_W-1:0] cap_limit;
  queue_result_t    expected_results [$];
  int               mismatches = 0;

  assign fail_count = mismatches;

  function automatic void note_result(input logic ok, input logic [IW-1:0] data,
                                      input logic [TW-1:0] found_tag, input logic last);
    queue_result_t r;
    r.ok         = ok;
    r.data       = data;
    r.found_tag  = found_tag;
    r.count      = CNT_W'(q_len);
    r.head_value = (q_len != 0) ? q_value[0] : '0;
    r.tail_value = (q_len != 0) ? q_value[q_len-1] : '0;
    r.last       = last;
    expected_results.push_back(r);
  endfunction

  function automatic void remove_entry(input int unsigned pos);
    for (int unsigned i = pos; i + 1 < q_len; i++) begin
      q_value[i] = q_value[i+1];
      q_tag[i]   = q_tag[i+1];
    end
    q_len--;
  endfunction

  function automatic void apply_request(input logic [OP_W-1:0] op,
                                        input logic [IW-1:0] value,
                                        input logic [TW-1:0] tag);
    int unsigned   lim;
    int unsigned   hit;
    logic [IW-1:0] popped;
    lim = (cap_limit > DEPTH) ? DEPTH : cap_limit;
    hit = q_len;
    case (op)
      OP_PUSH: begin
        if (q_len >= lim) begin
          note_result(1'b0, '0, '0, 1'b1);
        end else begin
          q_tag[q_len]   = (q_len != 0) ? q_tag[q_len-1] + 1'b1 : TW'(1);
          q_value[q_len] = value;
          q_len++;
          note_result(1'b1, '0, '0, 1'b1);
        end
      end
      OP_POP: begin
        if (q_len == 0) begin
          note_result(1'b0, '0, '0, 1'b1);
        end else begin
          popped = q_value[0];
          remove_entry(0);
          note_result(1'b1, popped, '0, 1'b1);
        end
      end
      OP_SEARCH: begin
        for (int unsigned i = 0; i < q_len; i++)
          if (hit == q_len && q_value[i] == value) hit = i;
        if (hit < q_len) note_result(1'b1, '0, q_tag[hit], 1'b1);
        else note_result(1'b0, '0, '0, 1'b1);
      end
      OP_DELETE: begin
        for (int unsigned i = 0; i < q_len; i++)
          if (hit == q_len && tag != '0 && q_tag[i] == tag) hit = i;
        if (hit < q_len) begin
          remove_entry(hit);
          note_result(1'b1, '0, '0, 1'b1);
        end else begin
          note_result(1'b0, '0, '0, 1'b1);
        end
      end
      OP_CLEAR: begin
        q_len = 0;
        note_result(1'b1, '0, '0, 1'b1);
      end
      OP_DUMP: begin
        if (q_len == 0) note_result(1'b0, '0, '0, 1'b1);
        for (int unsigned i = 0; i < q_len; i++)
          note_result(1'b1, q_value[i], q_tag[i], i + 1 == q_len);
      end
      default: note_result(1'b0, '0, '0, 1'b1);
    endcase
  endfunction

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0h, actual %0h", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin : track
    queue_result_t want;
    if (rst) begin
      q_len     = 0;
      cap_limit = CAP_RESET;
      expected_results.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr[ADDR_W-1] == REG_CAPACITY)
        cap_limit = pwdata[CAP_W-1:0];
      if (s_tvalid && s_tready)
        apply_request(s_tdata[OP_W-1:0], s_tdata[OP_W +: IW], s_tdata[OP_W+IW +: TW]);
      if (m_tvalid && m_tready) begin
        if (expected_results.size() == 0) begin
          $error("result arrived with no request outstanding");
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          check_field("ok", want.ok, m_tdata[0]);
          check_field("data", want.data, m_tdata[DATA_LSB +: IW]);
          check_field("found_tag", want.found_tag, m_tdata[FTAG_LSB +: TW]);
          check_field("count", want.count, m_tdata[COUNT_LSB +: CNT_W]);
          check_field("head_value", want.head_value, m_tdata[HEAD_LSB +: IW]);
          check_field("tail_value", want.tail_value, m_tdata[TAIL_LSB +: IW]);
          check_field("last", want.last, m_tlast);
        end
      end
    end
    pending  <= expected_results.size();
    live_tag <= (q_len != 0) ? q_tag[q_len-1] : '0;
  end

endmodule

// File: dv/tb_tagged_fifo_with_search_delete.sv
// ----------------------------------------------------------------------------
// Tagged FIFO testbench
// Drives directed and random requests through the tagged FIFO under several
// capacity limits, with bursty requests and a stalling result consumer, and
// leaves the checking of results to the result checker beside the block.
// ----------------------------------------------------------------------------
module tb_tagged_fifo_with_search_delete
  import tfsd_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IW         = ITEM_BITS_DEF;
  localparam int TW         = TAG_BITS_DEF;
  localparam int S_W        = ((OP_W + IW + TW + 7) / 8) * 8;
  localparam int M_W        = ((1 + 3 * IW + TW + $clog2(DEPTH_DEF + 1) + 7) / 8) * 8;
  localparam int IDLE_LIMIT = 4000;
  localparam int HOLD_LEN   = 150;
  localparam int PHASES     = 6;
  localparam int PHASE_REQS = 34;

  localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

  logic              clk      = 1'b0;
  logic              rst      = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  // op, value, tag
  logic [S_W-1:0]    s_tdata  = '0;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  // ok, data, found_tag, count, head_value, tail_value
  logic [M_W-1:0]    m_tdata;
  logic              m_tlast;
  logic              psel     = 1'b0;
  logic              penable  = 1'b0;
  logic              pwrite   = 1'b0;
  logic [ADDR_W-1:0] paddr    = '0;
  logic [REG_W-1:0]  pwdata   = '0;
  logic [REG_W-1:0]  prdata;
  logic              pready;

  int                fail_count;
  int                pending;
  logic [TW-1:0]     live_tag;

  logic              hold_req    = 1'b0;
  logic              hold_done   = 1'b0;
  int                hold_left   = 0;
  int                seg_left    = 0;
  int                ready_mode  = 0;
  int                burst_left  = 0;
  int                idle_cycles = 0;
  logic [IW-1:0]     value_pool [8];
  int                phase_cap  [PHASES] = '{31, 16, 5, 9, 1, 17};
  int                phase_push [PHASES] = '{70, 45, 40, 35, 30, 55};

  always #4 clk = ~clk;

  tagged_fifo_with_search_delete dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  tfsd_queue_checker #(.S_W(S_W), .M_W(M_W)) u_checker (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .pready     (pready),
    .fail_count (fail_count),
    .pending    (pending),
    .live_tag   (live_tag)
  );

  // The consumer alternates between always ready, half ready and mostly stalled,
  // and once holds off long enough for the block to back up.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left != 0) begin
      m_tready  <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      m_tready  <= 1'b0;
      hold_left <= HOLD_LEN;
      hold_done <= 1'b1;
    end else begin
      if (seg_left == 0) begin
        seg_left   <= $urandom_range(1, 40);
        ready_mode <= $urandom_range(0, 2);
      end else begin
        seg_left <= seg_left - 1;
      end
      case (ready_mode)
        0: m_tready <= 1'b1;
        1: m_tready <= ($urandom_range(0, 1) == 1);
        default: m_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $error("no request or result moved for %0d cycles", IDLE_LIMIT);
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_request(input logic [OP_W-1:0] op, input logic [IW-1:0] value,
                              input logic [TW-1:0] tag);
    if (burst_left == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= S_W'({tag, value, op});
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic random_request(input int push_pct);
    logic [OP_W-1:0] op;
    logic [IW-1:0]   value;
    logic [TW-1:0]   tag;
    int              pick;
    if ($urandom_range(0, 99) < push_pct) begin
      op = OP_PUSH;
    end else begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4:     op = OP_POP;
        5, 6, 7, 8, 9:     op = OP_SEARCH;
        10, 11, 12, 13, 14: op = OP_DELETE;
        15:                op = OP_CLEAR;
        16, 17:            op = OP_DUMP;
        18:                op = OP_SPARE_LO;
        default:           op = OP_SPARE_HI;
      endcase
    end
    value = ($urandom_range(0, 1) == 1) ? value_pool[$urandom_range(0, 7)] : $urandom();
    pick  = $urandom_range(0, 19);
    if (pick == 0) tag = '0;
    else if (pick < 4) tag = $urandom();
    else tag = live_tag - TW'($urandom_range(0, 17));
    send_request(op, value, tag);
  endtask

  task automatic wait_drained();
    s_tvalid   <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (pending != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] limit);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_CAPACITY, 2'b00};
    pwdata  <= {(REG_W - CAP_W)'($urandom()), limit};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  initial begin
    value_pool[0] = '0;
    value_pool[1] = '1;
    for (int i = 2; i < 8; i++) value_pool[i] = $urandom();
    phase_cap[3] = $urandom_range(2, 15);
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Empty queue, unused op codes, duplicate values and deletes from the middle.
    send_request(OP_POP, '0, '0);
    send_request(OP_SEARCH, '0, '0);
    send_request(OP_DELETE, '0, TW'(1));
    send_request(OP_DUMP, '0, '0);
    send_request(OP_SPARE_LO, '1, '1);
    send_request(OP_SPARE_HI, '0, '0);
    send_request(OP_PUSH, '0, '0);
    send_request(OP_PUSH, '1, '0);
    send_request(OP_PUSH, IW'(32'h1234_5678), '0);
    send_request(OP_PUSH, '1, '1);
    send_request(OP_SEARCH, '1, '0);
    send_request(OP_SEARCH, IW'(32'hDEAD_BEEF), '0);
    send_request(OP_DELETE, '0, '0);
    send_request(OP_DELETE, '0, TW'(3));
    send_request(OP_DELETE, '0, '1);
    send_request(OP_DELETE, '0, TW'(4));
    send_request(OP_DUMP, '0, '0);
    send_request(OP_POP, '0, '0);
    send_request(OP_CLEAR, '0, '0);
    send_request(OP_DUMP, '0, '0);
    wait_drained();

    write_capacity(CAP_W'(1));
    send_request(OP_PUSH, IW'(32'hA5A5_5A5A), '0);
    send_request(OP_PUSH, '1, '0);
    send_request(OP_DUMP, '0, '0);
    send_request(OP_CLEAR, '0, '0);
    wait_drained();

    write_capacity(CAP_W'(0));
    send_request(OP_PUSH, '1, '0);
    send_request(OP_POP, '0, '0);
    wait_drained();

    for (int p = 0; p < PHASES; p++) begin
      write_capacity(CAP_W'(phase_cap[p]));
      if (p == 0) hold_req <= 1'b1;
      for (int n = 0; n < PHASE_REQS; n++) begin
        random_request(phase_push[p]);
        if (p == 2 && n == PHASE_REQS / 2) wait_drained();
      end
      wait_drained();
    end

    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// File: tagged_fifo_with_search_delete.f
+incdir+rtl/core
rtl/core/tfsd_pkg.sv
rtl/core/tfsd_cell.sv
rtl/core/tfsd_chain.sv
rtl/core/tagged_fifo_with_search_delete.sv
dv/tfsd_queue_checker.sv
dv/tb_tagged_fifo_with_search_delete.sv
